@@ hw/rtl/lcadc_pkg.sv @@
`default_nettype none

package lcadc_pkg;

    localparam int OFFSET_W  = 25;
    localparam int READING_W = 26;
    localparam int CPU_W     = 31;
    localparam int TARE_W    = 8;
    localparam int CFG_W     = 31;
    localparam int CFG_IDX_W = 2;

    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_TARE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CPU    = 2'd2;

    localparam logic [1:0] GAIN_128 = 2'd0;
    localparam logic [1:0] GAIN_64  = 2'd1;
    localparam logic [1:0] GAIN_32  = 2'd2;

    localparam logic [READING_W-1:0] READING_MAX = 26'h1FF_FFFF;
    localparam logic [READING_W-1:0] READING_MIN = 26'h200_0000;
    localparam logic [OFFSET_W-1:0]  OFFSET_MAX  = 25'h0FF_FFFF;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    function automatic logic [1:0] extra_for_gain(input logic [1:0] gain);
        logic [1:0] extra;
        case (gain)
            GAIN_64: extra = 2'd3;
            GAIN_32: extra = 2'd2;
            default: extra = 2'd1;
        endcase
        return extra;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/lcadc_div.sv @@
`default_nettype none

module lcadc_div
    import lcadc_pkg::*;
#(
    parameter int DVD_W = 32,
    parameter int DVS_W = 31
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [DVD_W-1:0] dividend,
    input  wire logic [DVS_W-1:0] divisor,
    output logic      [DVD_W-1:0] quotient,
    output div_stat_t             stat
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVD_W-1:0] quot_reg, quot_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [DVS_W:0]   cand;
    logic [DVS_W:0]   trial;
    logic             ge;

    always_comb begin
        cand      = {rem_reg, quot_reg[DVD_W-1]};
        trial     = cand - {1'b0, dvs_reg};
        ge        = ~trial[DVS_W];
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DVD_W);
            rem_next  = '0;
            quot_next = dividend;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            rem_next  = ge ? trial[DVS_W-1:0] : cand[DVS_W-1:0];
            quot_next = {quot_reg[DVD_W-2:0], ge};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        dvs_reg  <= dvs_next;
    end

    assign quotient  = quot_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire

@@ hw/rtl/load_cell_adc_serial_reader.sv @@
// A request that ends no reading goes through ST_EMIT, where its result is loaded into
// the output register once that is free. A reading ending with a known offset adds a
// bit-serial divide in ST_RDIV; a tare completion adds another in ST_TDIV.
// Throughput: one request at a time; the serial divider sets the worst case.
// Reset (aresetn, synchronous, active low) clears control state and loads the
// register reset values; no clearing pass follows.
`default_nettype none

module load_cell_adc_serial_reader
    import lcadc_pkg::*;
#(
    parameter int DATA_BITS = 24
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // [0] dout_level, [8:1] tare_count, [15:9] zero
    input  wire logic [15:0]          s_tdata,
    // [0] func
    input  wire logic                 s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // [0] sck_pulse, [1] reading_valid, [27:2] reading, [28] tare_done,
    // [29] busy_res, [31:30] zero
    output logic [31:0]               m_tdata,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_addr,
    input  wire logic [CFG_W-1:0]     cfg_wdata
);

    localparam int PL_W  = $clog2(DATA_BITS + 4);
    localparam int MAG_W = ((DATA_BITS > 24) ? DATA_BITS : 24) + 1;
    localparam int SUM_W = DATA_BITS + 8;
    localparam int DVD_W = (MAG_W > SUM_W) ? MAG_W : SUM_W;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_RDIV = 4'b0010,
        ST_TDIV = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

    state_t                 state_reg, state_next;
    logic [1:0]             gain_reg, gain_next;
    logic [CPU_W-1:0]       cpu_reg, cpu_next;
    logic                   active_reg, active_next;
    logic [PL_W-1:0]        pulses_reg, pulses_next;
    logic [1:0]             extra_reg, extra_next;
    logic [DATA_BITS-1:0]   shift_reg, shift_next;
    logic [OFFSET_W-1:0]    offset_reg, offset_next;
    logic                   known_reg, known_next;
    logic                   tare_act_reg, tare_act_next;
    logic [TARE_W-1:0]      tare_left_reg, tare_left_next;
    logic [TARE_W-1:0]      tare_total_reg, tare_total_next;
    logic [SUM_W-1:0]       tare_sum_reg, tare_sum_next;
    logic                   tare_pend_reg, tare_pend_next;
    logic                   neg_reg, neg_next;
    logic                   res_sck_reg, res_sck_next;
    logic                   res_valid_reg, res_valid_next;
    logic                   res_done_reg, res_done_next;
    logic                   res_busy_reg, res_busy_next;
    logic [READING_W-1:0]   res_reading_reg, res_reading_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [31:0]            m_tdata_reg, m_tdata_next;

    logic                   in_fire;
    logic                   level;
    logic [TARE_W-1:0]      tcount;
    logic [DATA_BITS-1:0]   shift_eff;
    logic [DATA_BITS-1:0]   raw;
    logic [MAG_W:0]         raw_ext;
    logic [MAG_W:0]         diff;
    logic [MAG_W:0]         mag;
    logic [CPU_W-1:0]       cpu_eff;
    logic [SUM_W-1:0]       sum_add;
    logic [READING_W-1:0]   raw_sat;
    logic                   div_start;
    logic [DVD_W-1:0]       div_dvd;
    logic [CPU_W-1:0]       div_dvs;
    logic [DVD_W-1:0]       div_quot;
    div_stat_t              div_stat;
    logic                   out_free;

    lcadc_div #(
        .DVD_W (DVD_W),
        .DVS_W (CPU_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .quotient (div_quot),
        .stat     (div_stat)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign level    = s_tdata[0];
    assign tcount   = s_tdata[8:1];
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        shift_eff = (pulses_reg > PL_W'(extra_reg)) ? {shift_reg[DATA_BITS-2:0], level}
                                                   : shift_reg;
        raw       = {~shift_eff[DATA_BITS-1], shift_eff[DATA_BITS-2:0]};
        raw_ext   = {{(MAG_W + 1 - DATA_BITS){1'b0}}, raw};
        diff      = raw_ext - {{(MAG_W + 1 - OFFSET_W){offset_reg[OFFSET_W-1]}}, offset_reg};
        mag       = diff[MAG_W] ? (~diff + 1'b1) : diff;
        cpu_eff   = (cpu_reg == '0) ? CPU_W'(1) : cpu_reg;
        sum_add   = tare_sum_reg + SUM_W'(raw);
        raw_sat   = (raw_ext > (MAG_W + 1)'(READING_MAX)) ? READING_MAX
                                                           : raw_ext[READING_W-1:0];

        state_next       = state_reg;
        gain_next        = gain_reg;
        cpu_next         = cpu_reg;
        active_next      = active_reg;
        pulses_next      = pulses_reg;
        extra_next       = extra_reg;
        shift_next       = shift_reg;
        offset_next      = offset_reg;
        known_next       = known_reg;
        tare_act_next    = tare_act_reg;
        tare_left_next   = tare_left_reg;
        tare_total_next  = tare_total_reg;
        tare_sum_next    = tare_sum_reg;
        tare_pend_next   = tare_pend_reg;
        neg_next         = neg_reg;
        res_sck_next     = res_sck_reg;
        res_valid_next   = res_valid_reg;
        res_done_next    = res_done_reg;
        res_busy_next    = res_busy_reg;
        res_reading_next = res_reading_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        m_tdata_next     = m_tdata_reg;
        div_start        = 1'b0;
        div_dvd          = DVD_W'(mag[MAG_W-1:0]);
        div_dvs          = cpu_eff;

        if (cfg_wr_en) begin
            case (cfg_addr)
                REG_GAIN: gain_next = cfg_wdata[1:0];
                REG_OFFSET: begin
                    offset_next = cfg_wdata[OFFSET_W-1:0];
                    known_next  = |cfg_wdata[OFFSET_W-1:0];
                end
                REG_CPU: cpu_next = cfg_wdata[CPU_W-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    res_sck_next     = 1'b0;
                    res_valid_next   = 1'b0;
                    res_done_next    = 1'b0;
                    res_reading_next = '0;
                    tare_pend_next   = 1'b0;
                    res_busy_next    = active_reg;
                    state_next       = ST_EMIT;
                    if (s_tuser == FUNC_TARE) begin
                        if (tcount != '0) begin
                            tare_act_next   = 1'b1;
                            tare_left_next  = tcount;
                            tare_total_next = tcount;
                            tare_sum_next   = '0;
                            known_next      = 1'b0;
                        end
                    end else if (!active_reg) begin
                        if (!level) begin
                            extra_next    = extra_for_gain(gain_reg);
                            pulses_next   = PL_W'(DATA_BITS) + PL_W'(extra_for_gain(gain_reg));
                            shift_next    = '0;
                            active_next   = 1'b1;
                            res_busy_next = 1'b1;
                        end
                    end else begin
                        res_sck_next = 1'b1;
                        shift_next   = shift_eff;
                        pulses_next  = pulses_reg - 1'b1;
                        if (pulses_reg == PL_W'(1)) begin
                            active_next      = 1'b0;
                            res_busy_next    = 1'b0;
                            res_valid_next   = 1'b1;
                            res_reading_next = raw_sat;
                            neg_next         = diff[MAG_W];
                            if (tare_act_reg) begin
                                tare_sum_next  = sum_add;
                                tare_left_next = tare_left_reg - 1'b1;
                                if (tare_left_reg == TARE_W'(1)) begin
                                    tare_act_next  = 1'b0;
                                    res_done_next  = 1'b1;
                                    tare_pend_next = 1'b1;
                                end
                            end
                            if (known_reg) begin
                                div_start  = 1'b1;
                                state_next = ST_RDIV;
                            end else if (tare_act_reg && tare_left_reg == TARE_W'(1)) begin
                                div_start  = 1'b1;
                                div_dvd    = DVD_W'(sum_add);
                                div_dvs    = CPU_W'(tare_total_reg);
                                state_next = ST_TDIV;
                            end
                        end
                    end
                end
            end
            ST_RDIV: begin
                if (div_stat.done) begin
                    if (!neg_reg) begin
                        res_reading_next = (div_quot > DVD_W'(READING_MAX)) ? READING_MAX
                                         : div_quot[READING_W-1:0];
                    end else begin
                        res_reading_next = (div_quot > DVD_W'(READING_MIN)) ? READING_MIN
                                         : (~div_quot[READING_W-1:0] + 1'b1);
                    end
                    if (tare_pend_reg) begin
                        div_start  = 1'b1;
                        div_dvd    = DVD_W'(tare_sum_reg);
                        div_dvs    = CPU_W'(tare_total_reg);
                        state_next = ST_TDIV;
                    end else begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_TDIV: begin
                if (div_stat.done) begin
                    offset_next = (div_quot > DVD_W'(OFFSET_MAX)) ? OFFSET_MAX
                                : div_quot[OFFSET_W-1:0];
                    known_next  = 1'b1;
                    state_next  = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {2'b00, res_busy_reg, res_done_reg, res_reading_reg,
                                     res_valid_reg, res_sck_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            gain_reg       <= GAIN_128;
            cpu_reg        <= CPU_W'(1);
            active_reg     <= 1'b0;
            pulses_reg     <= '0;
            extra_reg      <= '0;
            shift_reg      <= '0;
            offset_reg     <= '0;
            known_reg      <= 1'b0;
            tare_act_reg   <= 1'b0;
            tare_left_reg  <= '0;
            tare_total_reg <= '0;
            tare_sum_reg   <= '0;
            tare_pend_reg  <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            gain_reg       <= gain_next;
            cpu_reg        <= cpu_next;
            active_reg     <= active_next;
            pulses_reg     <= pulses_next;
            extra_reg      <= extra_next;
            shift_reg      <= shift_next;
            offset_reg     <= offset_next;
            known_reg      <= known_next;
            tare_act_reg   <= tare_act_next;
            tare_left_reg  <= tare_left_next;
            tare_total_reg <= tare_total_next;
            tare_sum_reg   <= tare_sum_next;
            tare_pend_reg  <= tare_pend_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
        neg_reg         <= neg_next;
        res_sck_reg     <= res_sck_next;
        res_valid_reg   <= res_valid_next;
        res_done_reg    <= res_done_next;
        res_busy_reg    <= res_busy_next;
        res_reading_reg <= res_reading_next;
        m_tdata_reg     <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_active_pulses: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> (pulses_reg != '0))
        else $error("read in progress with no pulses left");

    a_tare_total: assert property (@(posedge aclk) disable iff (!aresetn)
        tare_act_reg |-> (tare_total_reg != '0) && (tare_left_reg != '0)
                         && (tare_left_reg <= tare_total_reg))
        else $error("tare counters out of step");

    a_div_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |-> (state_reg == ST_RDIV || state_reg == ST_TDIV))
        else $error("divider finished outside a divide state");

    a_div_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.busy |-> !s_tready)
        else $error("request taken while divider busy");

    a_emit_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && out_free) |=> m_tvalid_reg && state_reg == ST_IDLE)
        else $error("result not loaded into output register");

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
    import lcadc_pkg::*;

    localparam int DATA_BITS = 24;
    localparam int LIMIT = 2_000_000;
    localparam logic [1:0] GAIN_UNUSED = 2'd3;
    localparam longint RD_HI = 33554431;
    localparam longint RD_LO = -33554432;
    localparam longint OFS_HI = 16777215;

    typedef struct {
        logic                 sck;
        logic                 valid;
        logic [READING_W-1:0] reading;
        logic                 done;
        logic                 busy;
    } sample_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [15:0]          s_tdata = '0;
    logic                 s_tuser = FUNC_TICK;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [31:0]          m_tdata;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr = REG_GAIN;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    sample_t sample_q[$];
    int      errors = 0;
    int      items_sent = 0;
    int      cycle_cnt = 0;
    int      send_idle_pct = 6;
    int      recv_idle_pct = 85;
    bit      hold_start = 1'b0;
    int      hold_left = 0;

    // reader state as predicted
    logic [1:0]          rd_gain = GAIN_128;
    logic [CPU_W-1:0]    rd_cpu = CPU_W'(1);
    longint              rd_offset = 0;
    logic                rd_off_known = 1'b0;
    logic                rd_active = 1'b0;
    int                  rd_pulses = 0;
    int                  rd_extra = 0;
    logic [DATA_BITS-1:0] rd_shift = '0;
    logic                tare_active = 1'b0;
    int                  tare_left = 0;
    int                  tare_total = 0;
    longint unsigned     tare_sum = 0;

    load_cell_adc_serial_reader #(.DATA_BITS(DATA_BITS)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt >= LIMIT) begin
            $display("[load_cell_adc_serial_reader] ERROR");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (hold_start) begin
            hold_left = 400;
            hold_start = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin : check_results
        sample_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (sample_q.size() == 0) begin
                $error("unexpected result %h", m_tdata);
                errors++;
            end else begin
                want = sample_q.pop_front();
                if (m_tdata[0] !== want.sck) begin
                    $error("sck_pulse: expected %0d, got %0d", want.sck, m_tdata[0]);
                    errors++;
                end
                if (m_tdata[1] !== want.valid) begin
                    $error("reading_valid: expected %0d, got %0d", want.valid, m_tdata[1]);
                    errors++;
                end
                if (m_tdata[27:2] !== want.reading) begin
                    $error("reading: expected %0d, got %0d",
                           $signed(want.reading), $signed(m_tdata[27:2]));
                    errors++;
                end
                if (m_tdata[28] !== want.done) begin
                    $error("tare_done: expected %0d, got %0d", want.done, m_tdata[28]);
                    errors++;
                end
                if (m_tdata[29] !== want.busy) begin
                    $error("busy_res: expected %0d, got %0d", want.busy, m_tdata[29]);
                    errors++;
                end
            end
        end
    end

    task automatic advance_reader(input logic fn, input logic lvl, input logic [7:0] cnt);
        sample_t         s;
        logic [DATA_BITS-1:0] raw;
        longint          q;
        longint          dvs;
        longint unsigned avg;
        s = '{default: 1'b0, reading: '0};
        if (fn == FUNC_TARE) begin
            if (cnt != 0) begin
                tare_active = 1'b1;
                tare_left = int'(cnt);
                tare_total = int'(cnt);
                tare_sum = 0;
                rd_off_known = 1'b0;
            end
        end else if (!rd_active) begin
            if (!lvl) begin
                case (rd_gain)
                    GAIN_64: rd_extra = 3;
                    GAIN_32: rd_extra = 2;
                    default: rd_extra = 1;
                endcase
                rd_pulses = DATA_BITS + rd_extra;
                rd_shift = '0;
                rd_active = 1'b1;
            end
        end else begin
            s.sck = 1'b1;
            if (rd_pulses > rd_extra) rd_shift = {rd_shift[DATA_BITS-2:0], lvl};
            if (rd_pulses > 0) rd_pulses--;
            if (rd_pulses == 0) begin
                raw = rd_shift ^ {1'b1, {(DATA_BITS - 1){1'b0}}};
                rd_active = 1'b0;
                s.valid = 1'b1;
                if (rd_off_known) begin
                    dvs = (rd_cpu == 0) ? longint'(1) : longint'(rd_cpu);
                    q = (longint'(raw) - rd_offset) / dvs;
                end else begin
                    q = longint'(raw);
                end
                if (q > RD_HI) q = RD_HI;
                if (q < RD_LO) q = RD_LO;
                s.reading = q[READING_W-1:0];
                if (tare_active) begin
                    tare_sum += 64'(raw);
                    if (tare_left > 0) tare_left--;
                    if (tare_left == 0) begin
                        avg = tare_sum / 64'(tare_total);
                        if (avg > OFS_HI) avg = OFS_HI;
                        rd_offset = longint'(avg);
                        rd_off_known = 1'b1;
                        tare_active = 1'b0;
                        s.done = 1'b1;
                    end
                end
            end
        end
        s.busy = rd_active;
        sample_q.push_back(s);
    endtask

    task automatic send_req(input logic fn, input logic lvl, input logic [7:0] cnt);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= fn;
        s_tdata <= {7'd0, cnt, lvl};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        advance_reader(fn, lvl, cnt);
        items_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sample_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_GAIN: rd_gain = val[1:0];
            REG_OFFSET: begin
                rd_offset = longint'($signed(val[OFFSET_W-1:0]));
                rd_off_known = (rd_offset != 0);
            end
            REG_CPU: rd_cpu = val[CPU_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // finish a read already under way, or start one after a few idle ticks
    task automatic send_read(input logic [DATA_BITS-1:0] word);
        if (!rd_active) begin
            repeat ($urandom_range(0, 2)) send_req(FUNC_TICK, 1'b1, 8'($urandom));
            send_req(FUNC_TICK, 1'b0, 8'($urandom));
        end
        while (rd_active) begin
            if ($urandom_range(99) == 0)
                send_req(FUNC_TARE, 1'($urandom), 8'($urandom_range(1, 3)));
            else if (rd_pulses > rd_extra)
                send_req(FUNC_TICK, word[rd_pulses - rd_extra - 1], 8'($urandom));
            else
                send_req(FUNC_TICK, 1'($urandom), 8'($urandom));
        end
    endtask

    task automatic test_raw_words();
        send_req(FUNC_TICK, 1'b1, 8'h00);
        send_req(FUNC_TARE, 1'b0, 8'h00);
        send_read(24'h000000);
        send_read(24'hFFFFFF);
        send_read(24'h800000);
        send_read(24'h7FFFFF);
    endtask

    task automatic test_gain_codes();
        set_reg(REG_GAIN, CFG_W'(GAIN_64));
        send_read(24'($urandom));
        set_reg(REG_GAIN, CFG_W'(GAIN_32));
        send_read(24'($urandom));
        set_reg(REG_GAIN, CFG_W'(GAIN_UNUSED));
        send_read(24'($urandom));
        set_reg(REG_GAIN, CFG_W'(GAIN_32));
        send_req(FUNC_TICK, 1'b0, 8'($urandom));
        repeat (5) send_req(FUNC_TICK, 1'($urandom), 8'($urandom));
        set_reg(REG_GAIN, CFG_W'(GAIN_64));
        send_read(24'($urandom));
        send_read(24'($urandom));
        set_reg(REG_GAIN, CFG_W'(GAIN_128));
    endtask

    task automatic test_offset_and_scale();
        set_reg(REG_OFFSET, CFG_W'(-16777216));
        set_reg(REG_CPU, CFG_W'(1));
        send_read(24'hFFFFFF);
        send_read(24'h000000);
        set_reg(REG_OFFSET, CFG_W'(16777215));
        send_read(24'h800000);
        send_read(24'h7FFFFF);
        set_reg(REG_OFFSET, CFG_W'(1));
        set_reg(REG_CPU, 31'h7FFF_FFFF);
        send_read(24'hFFFFFF);
        set_reg(REG_OFFSET, CFG_W'(-5));
        set_reg(REG_CPU, CFG_W'(0));
        send_read(24'($urandom));
        set_reg(REG_OFFSET, CFG_W'(1000));
        set_reg(REG_CPU, CFG_W'(7));
        send_read(24'($urandom));
        send_read(24'h7FFFFF);
        set_reg(REG_OFFSET, CFG_W'(0));
        send_read(24'($urandom));
        set_reg(REG_CPU, CFG_W'(1));
    endtask

    task automatic test_tare();
        send_req(FUNC_TARE, 1'b0, 8'd2);
        send_read(24'($urandom));
        send_read(24'($urandom));
        send_read(24'($urandom));
        send_req(FUNC_TARE, 1'b1, 8'd255);
        send_read(24'($urandom));
        send_req(FUNC_TARE, 1'b0, 8'd1);
        send_read(24'($urandom));
        send_req(FUNC_TARE, 1'b0, 8'd3);
        send_read(24'($urandom));
        set_reg(REG_OFFSET, CFG_W'(500));
        send_read(24'($urandom));
        send_read(24'($urandom));
        send_read(24'($urandom));
        send_req(FUNC_TARE, 1'b0, 8'd2);
        send_req(FUNC_TARE, 1'b1, 8'd0);
        send_read(24'hFFFFFF);
        send_read(24'hFFFFFF);
        send_req(FUNC_TICK, 1'b0, 8'($urandom));
        repeat (10) send_req(FUNC_TICK, 1'($urandom), 8'($urandom));
        send_req(FUNC_TARE, 1'b0, 8'd1);
        send_read(24'($urandom));
        send_read(24'($urandom));
    endtask

    task automatic test_backpressure();
        drain();
        hold_start = 1'b1;
        send_read(24'($urandom));
        send_read(24'($urandom));
        drain();
        send_read(24'($urandom));
    endtask

    task automatic test_random();
        int target;
        int next_cfg;
        int pick;
        logic [DATA_BITS-1:0] word;
        logic [OFFSET_W-1:0]  ofs;
        logic [CFG_W-1:0]     cpu;
        next_cfg = items_sent + 150;
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin send_idle_pct = 6;  recv_idle_pct = 85; end
                1: begin send_idle_pct = 85; recv_idle_pct = 6;  end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            target = items_sent + 330;
            while (items_sent < target) begin
                if (items_sent >= next_cfg) begin
                    set_reg(REG_GAIN, CFG_W'($urandom_range(3)));
                    pick = $urandom_range(99);
                    if (pick < 10) ofs = 25'h100_0000;
                    else if (pick < 20) ofs = 25'h0FF_FFFF;
                    else if (pick < 30) ofs = '0;
                    else ofs = 25'($urandom);
                    set_reg(REG_OFFSET, {{(CFG_W - OFFSET_W){ofs[OFFSET_W-1]}}, ofs});
                    pick = $urandom_range(99);
                    if (pick < 50) cpu = CFG_W'($urandom_range(1, 300));
                    else if (pick < 90) cpu = CFG_W'($urandom_range(1, 32'h7FFF_FFFF));
                    else if (pick < 95) cpu = 31'h7FFF_FFFF;
                    else cpu = '0;
                    set_reg(REG_CPU, cpu);
                    next_cfg = items_sent + 150;
                end
                pick = $urandom_range(99);
                if (pick < 80) begin
                    case ($urandom_range(19))
                        0: word = '0;
                        1: word = '1;
                        2: word = 24'h800000;
                        3: word = 24'h7FFFFF;
                        default: word = 24'($urandom);
                    endcase
                    send_read(word);
                end else if (pick < 88) begin
                    repeat ($urandom_range(1, 6))
                        send_req(FUNC_TICK, 1'($urandom), 8'($urandom));
                end else if (pick < 95) begin
                    send_req(FUNC_TARE, 1'($urandom), 8'($urandom_range(1, 4)));
                end else begin
                    send_req(FUNC_TARE, 1'($urandom), 8'($urandom_range(0, 255)));
                end
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_raw_words();
        test_gain_codes();
        test_offset_and_scale();
        test_tare();
        test_backpressure();
        test_random();
        drain();
        repeat (100) @(posedge aclk);
        if (sample_q.size() != 0) begin
            $error("%0d results never arrived", sample_q.size());
            errors++;
        end
        if (errors == 0) begin
            $display("[load_cell_adc_serial_reader] OK");
        end else begin
            $display("[load_cell_adc_serial_reader] ERROR");
        end
        $finish;
    end

endmodule
